FILE: rtl/cle_pkg.sv
// cle_pkg: shared types and constants for the cursor line editor
// command codes, field widths and the controller/datapath handshake structs
// no dependencies
`timescale 1ns / 1ps

package cle_pkg;

  localparam int KIND_W = 3;
  localparam int CHAR_W = 8;

  localparam logic [KIND_W-1:0] KIND_LEFT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RIGHT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BACK    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INSERT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READOUT = 3'd4;

  typedef struct packed {
    logic accept;
    logic commit;
    logic emit;
  } cle_cmd_t;

  typedef struct packed {
    logic start_walk;
    logic walk_last;
    logic out_free;
  } cle_status_t;

endpackage

FILE: rtl/cle_ram.sv
// cle_ram: generic single write port, single read port ram
// registered read data, no reset on contents
// no dependencies
`timescale 1ns / 1ps

module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/cle_ctrl.sv
// cle_ctrl: command sequencer for the cursor line editor
// decides when a word is taken, when an edit commits and when readout steps
// depends on cle_pkg
`timescale 1ns / 1ps

module cle_ctrl
  import cle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cle_status_t status,
  output cle_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_WALK = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_next = status.start_walk ? ST_WALK : ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.walk_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: rtl/cle_datapath.sv
// cle_datapath: left and right stacks, counts, readout walk and output register
// two cle_ram instances hold the stack contents
// depends on cle_pkg and cle_ram
`timescale 1ns / 1ps

module cle_datapath
  import cle_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [KIND_W-1:0] kind,
  input  logic [CHAR_W-1:0] char_in,
  input  cle_cmd_t          cmd,
  output cle_status_t       status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] char_out,
  output logic              has_char,
  output logic              last,
  output logic              refused
);

  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int IW = (BUFFER_DEPTH > 2) ? $clog2(BUFFER_DEPTH) : 1;

  logic [CW-1:0]     left_count, right_count, pos;
  logic [KIND_W-1:0] kind_q;
  logic [CHAR_W-1:0] char_q;

  logic [CW-1:0]     total, left_m1, right_m1, pos_inc, right_walk;
  logic              full, load;
  logic              left_we, right_we, rd_en;
  logic [IW-1:0]     left_waddr, right_waddr, left_raddr, right_raddr;
  logic [CHAR_W-1:0] left_wdata, left_rdata, right_rdata;

  assign total      = left_count + right_count;
  assign left_m1    = left_count - CW'(1);
  assign right_m1   = right_count - CW'(1);
  assign pos_inc    = pos + CW'(1);
  assign right_walk = total - pos_inc - CW'(1);
  assign full       = (total >= CW'(BUFFER_DEPTH));

  assign status.start_walk = (kind == KIND_READOUT) && (total != '0);
  assign status.walk_last  = (pos_inc == total);
  assign status.out_free   = !out_valid || out_ready;

  assign load  = cmd.commit || cmd.emit;
  assign rd_en = cmd.accept || (cmd.emit && !status.walk_last);

  // read addresses: stack tops for edits, first byte or next byte for readout
  always_comb begin
    if (cmd.accept) begin
      left_raddr  = (kind == KIND_READOUT) ? '0 : left_m1[IW-1:0];
      right_raddr = right_m1[IW-1:0];
    end else begin
      left_raddr  = pos_inc[IW-1:0];
      right_raddr = right_walk[IW-1:0];
    end
  end

  // edit writes
  always_comb begin
    left_we     = 1'b0;
    right_we    = 1'b0;
    left_waddr  = left_count[IW-1:0];
    right_waddr = right_count[IW-1:0];
    left_wdata  = right_rdata;
    if (cmd.commit) begin
      unique case (kind_q)
        KIND_LEFT:   right_we = (left_count != '0);
        KIND_RIGHT:  left_we  = (right_count != '0);
        KIND_INSERT: begin
          left_we    = !full;
          left_wdata = char_q;
        end
        default: ;
      endcase
    end
  end

  cle_ram #(.WIDTH(CHAR_W), .DEPTH(BUFFER_DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (left_we),
    .waddr (left_waddr),
    .wdata (left_wdata),
    .re    (rd_en),
    .raddr (left_raddr),
    .rdata (left_rdata)
  );

  cle_ram #(.WIDTH(CHAR_W), .DEPTH(BUFFER_DEPTH)) u_right_ram (
    .clk   (clk),
    .we    (right_we),
    .waddr (right_waddr),
    .wdata (left_rdata),
    .re    (rd_en),
    .raddr (right_raddr),
    .rdata (right_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        unique case (kind_q)
          KIND_LEFT: begin
            if (left_count != '0) begin
              left_count  <= left_m1;
              right_count <= right_count + CW'(1);
            end
          end
          KIND_RIGHT: begin
            if (right_count != '0) begin
              right_count <= right_m1;
              left_count  <= left_count + CW'(1);
            end
          end
          KIND_BACK: begin
            if (left_count != '0) begin
              left_count <= left_m1;
            end
          end
          KIND_INSERT: begin
            if (!full) begin
              left_count <= left_count + CW'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q <= kind;
      char_q <= char_in;
      pos    <= '0;
    end else if (cmd.emit) begin
      pos <= pos_inc;
    end
    if (cmd.commit) begin
      char_out <= '0;
      has_char <= 1'b0;
      last     <= 1'b1;
      refused  <= (kind_q == KIND_INSERT) && full;
    end else if (cmd.emit) begin
      char_out <= (pos < left_count) ? left_rdata : right_rdata;
      has_char <= 1'b1;
      last     <= status.walk_last;
      refused  <= 1'b0;
    end
  end

endmodule

FILE: rtl/cursor_line_editor.sv
// cursor_line_editor: line edit buffer with a cursor, held as two stacks
// top level joining cle_ctrl and cle_datapath
// depends on cle_pkg, cle_ctrl, cle_datapath, cle_ram
//
//   channel | handshake            | word
//   in      | in_valid / in_ready  | kind, char_in
//   out     | out_valid / out_ready| char_out, has_char, last, refused
//
// an edit command is accepted with the stack top read, then the ram write and
// count update that loads the status word follow once the out channel is free
// a readout reads the ram once per byte, one byte per cycle while out is not stalled
// reset clears both counts; stack contents are not cleared
// a stalled out channel holds the sequencer, in_ready is high only when idle
`timescale 1ns / 1ps

module cursor_line_editor
  import cle_pkg::*;
#(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [CHAR_W-1:0] char_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] char_out,
  output logic              has_char,
  output logic              last,
  output logic              refused
);

  cle_cmd_t    cmd;
  cle_status_t status;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cle_datapath #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .kind      (kind),
    .char_in   (char_in),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_out  (char_out),
    .has_char  (has_char),
    .last      (last),
    .refused   (refused)
  );

endmodule
